// ===== rtl/core/sorted_integer_set_store_defines.svh =====
// Assertion helpers used by the sorted set store top module.
`ifndef SORTED_INTEGER_SET_STORE_DEFINES_SVH
`define SORTED_INTEGER_SET_STORE_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define SSIS_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define SSIS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/ssis_pkg.sv =====
`timescale 1ns / 1ps
package ssis_pkg;

   localparam int CAPACITY = 64;
   localparam int DATA_W   = 32;
   localparam int OP_W     = 3;
   localparam int COUNT_W  = 7;
   localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   localparam logic [OP_W-1:0] OP_INSERT = OP_W'(0);
   localparam logic [OP_W-1:0] OP_REMOVE = OP_W'(1);
   localparam logic [OP_W-1:0] OP_TEST   = OP_W'(2);
   localparam logic [OP_W-1:0] OP_XMIN   = OP_W'(3);
   localparam logic [OP_W-1:0] OP_XMAX   = OP_W'(4);

   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [DATA_W-1:0] wr_data;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
   } mem_req_type;

   typedef struct packed {
      logic              valid;
      logic              ok;
      logic [DATA_W-1:0] value;
      logic [CNT_W-1:0]  fill;
   } done_type;

   // Element count as reported: fill modulo 2**COUNT_W.
   function automatic logic [COUNT_W-1:0] count_field(input logic [CNT_W-1:0] fill);
      logic [CNT_W+COUNT_W-1:0] wide;
      wide = {{COUNT_W{1'b0}}, fill};
      return wide[COUNT_W-1:0];
   endfunction

endpackage

// ===== rtl/core/ssis_ram.sv =====
`timescale 1ns / 1ps
module ssis_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 32,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/ssis_ctrl.sv =====
`timescale 1ns / 1ps
module ssis_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [ssis_pkg::OP_W-1:0]    req_opcode,
   input  logic signed [ssis_pkg::DATA_W-1:0] req_value,
   output ssis_pkg::mem_req_type        mem,
   input  logic [ssis_pkg::DATA_W-1:0]  rd_data,
   output ssis_pkg::done_type           done
);
   import ssis_pkg::*;

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_SRD  = 4'd1;
   localparam logic [3:0] S_SCMP = 4'd2;
   localparam logic [3:0] S_DNRD = 4'd3;
   localparam logic [3:0] S_DNWR = 4'd4;
   localparam logic [3:0] S_UPRD = 4'd5;
   localparam logic [3:0] S_UPWR = 4'd6;
   localparam logic [3:0] S_PUT  = 4'd7;
   localparam logic [3:0] S_MRD  = 4'd8;
   localparam logic [3:0] S_MCAP = 4'd9;

   logic [3:0]               state_ff, state_in;
   logic [OP_W-1:0]          op_ff, op_in;
   logic signed [DATA_W-1:0] val_ff, val_in;
   logic [CNT_W-1:0]         fill_ff, fill_in;
   logic [CNT_W-1:0]         idx_ff, idx_in;
   logic [CNT_W-1:0]         pos_ff, pos_in;
   logic [DATA_W-1:0]        res_ff, res_in;

   logic signed [DATA_W-1:0] rd_word;
   logic [CNT_W-1:0]         idx_next;
   logic [CNT_W-1:0]         idx_prev;
   logic [CNT_W-1:0]         fill_dec;
   logic [CNT_W-1:0]         fill_inc;
   logic                     last;
   logic                     empty;

   assign rd_word  = rd_data;
   assign idx_next = CNT_W'(idx_ff + 1'b1);
   assign idx_prev = CNT_W'(idx_ff - 1'b1);
   assign fill_dec = CNT_W'(fill_ff - 1'b1);
   assign fill_inc = CNT_W'(fill_ff + 1'b1);
   assign last     = (idx_next == fill_ff);
   assign empty    = (fill_ff == '0);
   assign busy     = (state_ff != S_IDLE);

   always_comb begin
      logic             hit;
      logic             search_end;
      logic [CNT_W-1:0] p;
      logic [CNT_W-1:0] p_next;

      state_in   = state_ff;
      op_in      = op_ff;
      val_in     = val_ff;
      fill_in    = fill_ff;
      idx_in     = idx_ff;
      pos_in     = pos_ff;
      res_in     = res_ff;
      mem        = '0;
      done       = '0;
      hit        = 1'b0;
      search_end = 1'b0;
      p          = idx_ff;
      p_next     = idx_next;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in  = req_opcode;
               val_in = req_value;
               idx_in = '0;
               case (req_opcode)
                  OP_INSERT: begin
                     if (fill_ff == CNT_W'(CAPACITY)) begin
                        done.valid = 1'b1;
                     end else if (empty) begin
                        pos_in   = '0;
                        state_in = S_PUT;
                     end else begin
                        state_in = S_SRD;
                     end
                  end
                  OP_REMOVE, OP_TEST: begin
                     if (empty) done.valid = 1'b1;
                     else       state_in   = S_SRD;
                  end
                  OP_XMIN: begin
                     if (empty) done.valid = 1'b1;
                     else       state_in   = S_MRD;
                  end
                  OP_XMAX: begin
                     if (empty) begin
                        done.valid = 1'b1;
                     end else begin
                        idx_in   = fill_dec;
                        state_in = S_MRD;
                     end
                  end
                  default: done.valid = 1'b1;
               endcase
            end
         end
         S_SRD: begin
            mem.rd_en   = 1'b1;
            mem.rd_addr = idx_ff[ADDR_W-1:0];
            state_in    = S_SCMP;
         end
         S_SCMP: begin
            // linear scan for the first entry not below the operand
            if (rd_word < val_ff) begin
               if (last) begin
                  p          = fill_ff;
                  search_end = 1'b1;
               end else begin
                  idx_in   = idx_next;
                  state_in = S_SRD;
               end
            end else begin
               hit        = (rd_word == val_ff);
               search_end = 1'b1;
            end
            p_next = CNT_W'(p + 1'b1);
            if (search_end) begin
               case (op_ff)
                  OP_TEST: begin
                     done.valid = 1'b1;
                     done.ok    = hit;
                  end
                  OP_REMOVE: begin
                     if (!hit) begin
                        done.valid = 1'b1;
                     end else if (p_next == fill_ff) begin
                        fill_in    = fill_dec;
                        done.valid = 1'b1;
                        done.ok    = 1'b1;
                     end else begin
                        idx_in   = p_next;
                        state_in = S_DNRD;
                     end
                  end
                  default: begin
                     if (hit) begin
                        done.valid = 1'b1;
                     end else if (p == fill_ff) begin
                        pos_in   = p;
                        state_in = S_PUT;
                     end else begin
                        pos_in   = p;
                        idx_in   = fill_dec;
                        state_in = S_UPRD;
                     end
                  end
               endcase
            end
         end
         S_DNRD: begin
            mem.rd_en   = 1'b1;
            mem.rd_addr = idx_ff[ADDR_W-1:0];
            state_in    = S_DNWR;
         end
         S_DNWR: begin
            // close the gap: entry moves one slot down
            mem.wr_en   = 1'b1;
            mem.wr_addr = idx_prev[ADDR_W-1:0];
            mem.wr_data = rd_data;
            if (last) begin
               fill_in    = fill_dec;
               done.valid = 1'b1;
               done.ok    = 1'b1;
               done.value = (op_ff == OP_XMIN) ? res_ff : '0;
            end else begin
               idx_in   = idx_next;
               state_in = S_DNRD;
            end
         end
         S_UPRD: begin
            mem.rd_en   = 1'b1;
            mem.rd_addr = idx_ff[ADDR_W-1:0];
            state_in    = S_UPWR;
         end
         S_UPWR: begin
            // open a hole at pos, top entry first
            mem.wr_en   = 1'b1;
            mem.wr_addr = idx_next[ADDR_W-1:0];
            mem.wr_data = rd_data;
            if (idx_ff == pos_ff) begin
               state_in = S_PUT;
            end else begin
               idx_in   = idx_prev;
               state_in = S_UPRD;
            end
         end
         S_PUT: begin
            mem.wr_en   = 1'b1;
            mem.wr_addr = pos_ff[ADDR_W-1:0];
            mem.wr_data = val_ff;
            fill_in     = fill_inc;
            done.valid  = 1'b1;
            done.ok     = 1'b1;
         end
         S_MRD: begin
            mem.rd_en   = 1'b1;
            mem.rd_addr = idx_ff[ADDR_W-1:0];
            state_in    = S_MCAP;
         end
         S_MCAP: begin
            if (op_ff == OP_XMAX || fill_ff == CNT_W'(1)) begin
               fill_in    = fill_dec;
               done.valid = 1'b1;
               done.ok    = 1'b1;
               done.value = rd_data;
            end else begin
               res_in   = rd_data;
               idx_in   = CNT_W'(1);
               state_in = S_DNRD;
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (done.valid) state_in = S_IDLE;
      done.fill = fill_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         fill_ff  <= '0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff  <= op_in;
      val_ff <= val_in;
      idx_ff <= idx_in;
      pos_ff <= pos_in;
      res_ff <= res_in;
   end

endmodule

// ===== rtl/core/sorted_integer_set_store.sv =====
// Sorted integer set store: up to CAPACITY distinct signed 32-bit values, ascending.
// Request: drive req_opcode and req_value with start; the item is taken at a clock
// edge where start is high and busy is low. Opcodes: insert, remove, member test,
// extract minimum, extract maximum; other codes are a no-op that fails.
// Result: one item per request on rsp_ok, rsp_out_value, rsp_count and rsp_is_empty,
// valid for the single cycle that rsp_strobe is high. The receiver cannot stall.
// Operation: the entries sit in one single-port-read, single-port-write RAM with a
// registered read, so each visited entry takes a read state, then a compare or move
// state. Member test, insert and remove scan up from slot 0 for the first entry not
// below the operand; an insert of a new value then moves the entries from the top
// down to that slot up by one and writes the operand there, while a remove moves the
// entries above the hit down by one. Extract max reads the top entry; extract min
// reads slot 0 and moves every other entry down by one. Test, remove or extract on
// an empty store, insert when full and a bad opcode finish in the accept cycle.
// The result strobe rises in the cycle after the item completes; busy falls in the
// same cycle, so the next item may be issued while the strobe is up.
// Reset (synchronous) empties the store and clears busy and the strobe; the RAM
// is not cleared since only slots below the fill count are ever read.
`timescale 1ns / 1ps
module sorted_integer_set_store (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [ssis_pkg::OP_W-1:0]          req_opcode,
   input  logic signed [ssis_pkg::DATA_W-1:0] req_value,
   output logic                               rsp_strobe,
   output logic                               rsp_ok,
   output logic signed [ssis_pkg::DATA_W-1:0] rsp_out_value,
   output logic [ssis_pkg::COUNT_W-1:0]       rsp_count,
   output logic                               rsp_is_empty
);
   import ssis_pkg::*;
   `include "sorted_integer_set_store_defines.svh"

   mem_req_type       mem;
   done_type          done;
   logic [DATA_W-1:0] rd_data;

   logic                     rsp_strobe_ff;
   logic                     rsp_ok_ff;
   logic signed [DATA_W-1:0] rsp_out_value_ff;
   logic [COUNT_W-1:0]       rsp_count_ff;
   logic                     rsp_is_empty_ff;

   ssis_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_opcode (req_opcode),
      .req_value  (req_value),
      .mem        (mem),
      .rd_data    (rd_data),
      .done       (done)
   );

   ssis_ram #(
      .DEPTH (CAPACITY),
      .WIDTH (DATA_W),
      .AW    (ADDR_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem.wr_en),
      .wr_addr (mem.wr_addr),
      .wr_data (mem.wr_data),
      .rd_en   (mem.rd_en),
      .rd_addr (mem.rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= done.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (done.valid) begin
         rsp_ok_ff        <= done.ok;
         rsp_out_value_ff <= done.value;
         rsp_count_ff     <= count_field(done.fill);
         rsp_is_empty_ff  <= (done.fill == '0);
      end
   end

   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_ok        = rsp_ok_ff;
   assign rsp_out_value = rsp_out_value_ff;
   assign rsp_count     = rsp_count_ff;
   assign rsp_is_empty  = rsp_is_empty_ff;

   `SSIS_ASSERT_NEXT(a_accept_progress, start && !busy, rsp_strobe || busy, "item dropped")
   `SSIS_ASSERT_NEXT(a_no_stray_result, !start && !busy, !rsp_strobe, "stray result")
   `SSIS_ASSERT_NOW(a_fail_value_zero, rsp_strobe && !rsp_ok, rsp_out_value == '0, "value on fail")

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
module tb;
   import ssis_pkg::*;

   localparam int STALL_LIMIT = 20000;
   localparam int TAIL_CYCLES = 400;
   localparam int PHASE_ITEMS = 545;
   localparam logic [OP_W-1:0] OP_NOP_LO = OP_W'(OP_XMAX + 1);
   localparam logic [OP_W-1:0] OP_NOP_HI = '1;
   localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
   localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;

   typedef struct {
      logic [OP_W-1:0]          opcode;
      logic signed [DATA_W-1:0] value;
   } command_type;

   typedef struct {
      logic                     ok;
      logic signed [DATA_W-1:0] out_value;
      logic [COUNT_W-1:0]       count;
      logic                     is_empty;
   } outcome_type;

   logic                        clock;
   logic                        reset = 1'b1;
   logic                        start = 1'b0;
   logic                        busy;
   logic [OP_W-1:0]             req_opcode = '0;
   logic signed [DATA_W-1:0]    req_value = '0;
   logic                        rsp_strobe;
   logic                        rsp_ok;
   logic signed [DATA_W-1:0]    rsp_out_value;
   logic [COUNT_W-1:0]          rsp_count;
   logic                        rsp_is_empty;

   command_type                 pending_cmds[$];
   command_type                 next_cmd;
   outcome_type                 results_due[$];
   outcome_type                 due;
   logic signed [DATA_W-1:0]    held[$];     // predicted set contents, ascending
   logic signed [DATA_W-1:0]    recent[$];   // values inserted lately, for hits
   logic                        took = 1'b0;
   int                          gap_pct = 8;
   int                          errors = 0;
   int                          n_taken = 0;
   int                          n_checked = 0;
   int                          stall_cycles = 0;

   sorted_integer_set_store dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_opcode    (req_opcode),
      .req_value     (req_value),
      .rsp_strobe    (rsp_strobe),
      .rsp_ok        (rsp_ok),
      .rsp_out_value (rsp_out_value),
      .rsp_count     (rsp_count),
      .rsp_is_empty  (rsp_is_empty)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic outcome_type apply_to_set(input logic [OP_W-1:0] op,
                                                input logic signed [DATA_W-1:0] v);
      outcome_type r;
      int          pos;
      logic        hit;
      pos = 0;
      while (pos < held.size() && held[pos] < v)
         pos++;
      hit = (pos < held.size()) && (held[pos] == v);
      r.ok = 1'b0;
      r.out_value = '0;
      case (op)
         OP_INSERT: begin
            if (!hit && held.size() < CAPACITY) begin
               held.insert(pos, v);
               r.ok = 1'b1;
            end
         end
         OP_REMOVE: begin
            if (hit) begin
               held.delete(pos);
               r.ok = 1'b1;
            end
         end
         OP_TEST: r.ok = hit;
         OP_XMIN: begin
            if (held.size() != 0) begin
               r.out_value = held.pop_front();
               r.ok = 1'b1;
            end
         end
         OP_XMAX: begin
            if (held.size() != 0) begin
               r.out_value = held.pop_back();
               r.ok = 1'b1;
            end
         end
         default: ;
      endcase
      r.count = COUNT_W'(held.size());
      r.is_empty = (held.size() == 0);
      return r;
   endfunction

   function automatic void compare_field(input string name, input logic [DATA_W-1:0] want,
                                         input logic [DATA_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
         errors++;
      end
   endfunction

   // Driver: a new item goes out only once the current one has been taken.
   always @(negedge clock) begin
      if (!reset && (!start || took)) begin
         if (pending_cmds.size() != 0 && $urandom_range(99) >= gap_pct) begin
            next_cmd = pending_cmds.pop_front();
            req_opcode <= next_cmd.opcode;
            req_value <= next_cmd.value;
            start <= 1'b1;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor: check results first, then predict the item taken at this edge.
   always @(posedge clock) begin
      if (reset) begin
         took <= 1'b0;
      end else begin
         if (rsp_strobe) begin
            if (results_due.size() == 0) begin
               $display("%0t: result with none expected, expected none, got ok=%0b value=%0h",
                        $time, rsp_ok, rsp_out_value);
               errors++;
            end else begin
               due = results_due.pop_front();
               compare_field("ok", DATA_W'(due.ok), DATA_W'(rsp_ok));
               compare_field("out_value", due.out_value, rsp_out_value);
               compare_field("count", DATA_W'(due.count), DATA_W'(rsp_count));
               compare_field("is_empty", DATA_W'(due.is_empty), DATA_W'(rsp_is_empty));
               n_checked <= n_checked + 1;
            end
         end
         if (start && !busy) begin
            results_due.push_back(apply_to_set(req_opcode, req_value));
            n_taken <= n_taken + 1;
         end
         took <= start && !busy;
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe)
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles == STALL_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   function automatic void queue_item(input logic [OP_W-1:0] op,
                                      input logic signed [DATA_W-1:0] v);
      command_type c;
      c.opcode = op;
      c.value = v;
      pending_cmds.push_back(c);
      if (op == OP_INSERT) begin
         recent.push_back(v);
         if (recent.size() > 48)
            void'(recent.pop_front());
      end
   endfunction

   function automatic logic signed [DATA_W-1:0] pick_value(input int fresh_pct);
      int r;
      r = $urandom_range(99);
      if (r < fresh_pct)
         return $urandom;
      if (r < 90 && recent.size() != 0)
         return recent[$urandom_range(recent.size() - 1)];
      if (r < 95)
         return $signed($urandom_range(16)) - 8;
      case ($urandom_range(3))
         0: return VAL_MIN;
         1: return VAL_MAX;
         2: return 0;
         default: return -1;
      endcase
   endfunction

   function automatic logic [OP_W-1:0] OP_OP_NOP();
      return OP_W'($urandom_range(OP_NOP_HI, OP_NOP_LO));
   endfunction

   function automatic logic [OP_W-1:0] pick_opcode();
      int r;
      r = $urandom_range(99);
      if (r < 35) return OP_INSERT;
      if (r < 55) return OP_REMOVE;
      if (r < 75) return OP_TEST;
      if (r < 85) return OP_XMIN;
      if (r < 95) return OP_XMAX;
      return OP_OP_NOP();
   endfunction

   // One burst: fill past capacity, drain past empty, or a random mix.
   function automatic int plan_burst();
      int kind;
      int n;
      kind = $urandom_range(9);
      if (kind < 2) begin
         n = $urandom_range(75, 60);
         for (int i = 0; i < n; i++)
            queue_item(OP_INSERT, pick_value(80));
      end else if (kind < 4) begin
         n = $urandom_range(70, 20);
         for (int i = 0; i < n; i++) begin
            if ($urandom_range(9) < 8)
               queue_item($urandom_range(1) ? OP_XMIN : OP_XMAX, $urandom);
            else
               queue_item($urandom_range(1) ? OP_TEST : OP_REMOVE, pick_value(10));
         end
      end else begin
         n = $urandom_range(40, 10);
         for (int i = 0; i < n; i++)
            queue_item(pick_opcode(), pick_value(25));
      end
      return n;
   endfunction

   // Hold off until every queued item has gone out and its result has come back.
   task automatic settle();
      do
         @(posedge clock);
      while (pending_cmds.size() != 0 || start || n_taken != n_checked);
   endtask

   initial begin
      int sent;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      queue_item(OP_INSERT, VAL_MIN);
      queue_item(OP_INSERT, VAL_MAX);
      queue_item(OP_INSERT, 0);
      queue_item(OP_INSERT, -1);
      queue_item(OP_INSERT, 1);
      queue_item(OP_INSERT, 0);          // duplicate
      queue_item(OP_TEST, VAL_MAX);
      queue_item(OP_TEST, 5);
      queue_item(OP_REMOVE, 5);          // absent
      queue_item(OP_REMOVE, 0);
      queue_item(OP_XMIN, $urandom);
      queue_item(OP_XMAX, $urandom);
      for (int op = OP_NOP_LO; op <= OP_NOP_HI; op++)
         queue_item(OP_W'(op), $urandom);
      queue_item(OP_XMIN, VAL_MAX);
      queue_item(OP_XMIN, VAL_MIN);
      queue_item(OP_XMIN, 0);            // empty
      queue_item(OP_XMAX, -1);           // empty
      queue_item(OP_REMOVE, 1);
      queue_item(OP_TEST, VAL_MIN);
      settle();

      for (int phase = 0; phase < 3; phase++) begin
         gap_pct = (phase == 0) ? 8 : (phase == 1) ? 84 : 0;
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            sent += plan_burst();
            if ($urandom_range(7) == 0)
               settle();
         end
         settle();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      if (errors == 0 && results_due.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
